[rtl/core/hshp_pkg.sv]
`timescale 1ns / 1ps

package hshp_pkg;

   // one received byte, or a link-down event
   typedef struct packed {
      logic [7:0] data_byte;
      logic       link_down;
   } req_word_type;

   // one status report
   typedef struct packed {
      logic [2:0] status;
      logic [7:0] code_first;
      logic [7:0] code_second;
      logic [7:0] code_third;
   } rsp_word_type;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [23:0] CODE_NNN = 24'h4E4E4E;
   localparam logic [23:0] CODE_200 = 24'h323030;
   localparam logic [23:0] CODE_400 = 24'h343030;
   localparam logic [23:0] CODE_500 = 24'h353030;
   localparam logic [23:0] CODE_503 = 24'h353033;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_BAD_REQUEST  = 3'd1;
   localparam logic [2:0] ST_SERVER_ERROR = 3'd2;
   localparam logic [2:0] ST_UNAVAILABLE  = 3'd3;
   localparam logic [2:0] ST_UNKNOWN      = 3'd4;
   localparam logic [2:0] ST_DISCONNECTED = 3'd5;

   function automatic logic [2:0] decode_code(input logic [23:0] chars);
      logic [2:0] st;
      st = ST_UNKNOWN;
      if (chars == CODE_200) st = ST_OK;
      else if (chars == CODE_400) st = ST_BAD_REQUEST;
      else if (chars == CODE_500) st = ST_SERVER_ERROR;
      else if (chars == CODE_503) st = ST_UNAVAILABLE;
      return st;
   endfunction

endpackage

[rtl/core/hshp_chan_if.sv]
`timescale 1ns / 1ps

interface hshp_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/http_status_header_parser_top.sv]
`timescale 1ns / 1ps

// HTTP response status-line parser. Takes one response byte per word on the
// req channel and sends at most one status word on the rsp channel: at the
// CR LF CR LF that ends the header it reports 200 / 400 / 500 / 503 / unknown
// from the three bytes after the first space of the status line, and a
// link-down word arriving before the header end reports "disconnected" with
// the code bytes captured so far (uncaptured bytes read as 'N'). Link-down
// always resets the parser; body bytes are dropped silently. Every word is
// handled in the cycle it is accepted, so one word per clock is sustained
// while req ready is high; the result sits in an output register backed by a
// one-word skid stage, and req ready drops only while that skid stage holds
// a word the sink has not yet taken.
module http_status_header_parser_top (
   input logic         clock,
   input logic         reset,
   hshp_chan_if.sink   req_chan,
   hshp_chan_if.source rsp_chan
);
   import hshp_pkg::*;

   // parser state
   logic [2:0]  line_end_count_ff, line_end_count_in;
   logic        past_status_line_ff, past_status_line_in;
   logic [1:0]  section_index_ff, section_index_in;
   logic [1:0]  capture_remaining_ff, capture_remaining_in;
   logic [23:0] code_chars_ff, code_chars_in;
   logic        in_body_ff, in_body_in;

   // output register and skid stage
   logic         out_valid_ff;
   rsp_word_type out_word_ff;
   logic         skid_valid_ff;
   rsp_word_type skid_word_ff;

   // result of the word being accepted
   logic         res_valid;
   rsp_word_type res_word;

   logic       req_accept;
   logic [7:0] c;
   logic       out_free;

   assign req_chan.ready = ~skid_valid_ff;
   assign req_accept     = req_chan.valid & req_chan.ready;
   assign c              = req_chan.payload.data_byte;

   // per-byte update
   always_comb begin
      line_end_count_in    = line_end_count_ff;
      past_status_line_in  = past_status_line_ff;
      section_index_in     = section_index_ff;
      capture_remaining_in = capture_remaining_ff;
      code_chars_in        = code_chars_ff;
      in_body_in           = in_body_ff;
      res_valid            = 1'b0;
      res_word.status      = ST_UNKNOWN;
      res_word.code_first  = code_chars_ff[23:16];
      res_word.code_second = code_chars_ff[15:8];
      res_word.code_third  = code_chars_ff[7:0];

      if (req_chan.payload.link_down) begin
         // disconnect: report only if still inside the header
         res_valid            = ~in_body_ff;
         res_word.status      = ST_DISCONNECTED;
         line_end_count_in    = 3'd0;
         past_status_line_in  = 1'b0;
         section_index_in     = 2'd0;
         capture_remaining_in = 2'd0;
         code_chars_in        = CODE_NNN;
         in_body_in           = 1'b0;
      end else if (in_body_ff) begin
         // body bytes are dropped
      end else if (capture_remaining_ff != 2'd0) begin
         // code capture, no cr/lf check
         case (capture_remaining_ff)
            2'd3:    code_chars_in[23:16] = c;
            2'd2:    code_chars_in[15:8]  = c;
            default: code_chars_in[7:0]   = c;
         endcase
         capture_remaining_in = capture_remaining_ff - 2'd1;
      end else begin
         // alternating cr/lf counter
         if ((c == CHAR_CR && !line_end_count_ff[0]) ||
             (c == CHAR_LF && line_end_count_ff[0])) begin
            line_end_count_in = line_end_count_ff + 3'd1;
         end else begin
            line_end_count_in = 3'd0;
         end

         if (line_end_count_in == 3'd2) begin
            past_status_line_in = 1'b1;
            if (section_index_ff < 2'd2) section_index_in = section_index_ff + 2'd1;
         end else if (line_end_count_in >= 3'd4) begin
            // blank line: header done
            in_body_in        = 1'b1;
            line_end_count_in = 3'd0;
            res_valid         = 1'b1;
            res_word.status   = decode_code(code_chars_ff);
         end

         // first space of the status line starts the code capture
         if (c == CHAR_SPACE && !past_status_line_in) begin
            if (section_index_in < 2'd2) section_index_in = section_index_in + 2'd1;
            if (section_index_in == 2'd1) capture_remaining_in = 2'd3;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_end_count_ff    <= 3'd0;
         past_status_line_ff  <= 1'b0;
         section_index_ff     <= 2'd0;
         capture_remaining_ff <= 2'd0;
         code_chars_ff        <= CODE_NNN;
         in_body_ff           <= 1'b0;
      end else if (req_accept) begin
         line_end_count_ff    <= line_end_count_in;
         past_status_line_ff  <= past_status_line_in;
         section_index_ff     <= section_index_in;
         capture_remaining_ff <= capture_remaining_in;
         code_chars_ff        <= code_chars_in;
         in_body_ff           <= in_body_in;
      end
   end

   // output register is free when empty or being drained this cycle
   assign out_free = ~out_valid_ff | rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            // skid word moves up; no new word was accepted this cycle
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_accept & res_valid;
         end
      end else if (req_accept && res_valid) begin
         // output stalled: park the new word
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) out_word_ff <= skid_word_ff;
         else out_word_ff <= res_word;
      end
      // a parked word is held until it moves up
      if (!out_free && !skid_valid_ff) skid_word_ff <= res_word;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_word_ff;

endmodule
